/* rtl/critical_point_distance_tracker_top_defines.svh */
// ----------------------------------------------------------------------------
// critical point distance tracker: assertion macros
// concurrent checks on the clock of the block, with and without reset gating
// ----------------------------------------------------------------------------
`ifndef CRITICAL_POINT_DISTANCE_TRACKER_TOP_DEFINES_SVH
`define CRITICAL_POINT_DISTANCE_TRACKER_TOP_DEFINES_SVH

// property checked only outside reset
`define CPDT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define CPDT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/cpdt_pkg.sv */
// ----------------------------------------------------------------------------
// cpdt_pkg
// shared types and constants of the critical point distance tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpdt_pkg;

	// width of the gap and span result fields
	localparam int unsigned RES_W = 16;

	// smallest gap before any gap was seen
	localparam logic [RES_W-1:0] GAP_NONE = '1;

	// classification of one sample, passed from front to back
	typedef struct packed {
		logic crit;
		logic last;
	} cpdt_ctl_t;

endpackage

/* rtl/cpdt_front.sv */
// ----------------------------------------------------------------------------
// cpdt_front
// keeps the sample history and classifies the middle sample as critical
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpdt_front #(
	parameter int unsigned MAX_LEN      = 65536,
	parameter int unsigned SAMPLE_WIDTH = 32,
	parameter int unsigned PW           = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [31:0]           sample_value,
	input  logic                  is_last,
	output cpdt_pkg::cpdt_ctl_t   ctl,
	output logic [PW-1:0]         pos
);
	import cpdt_pkg::*;

	localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic [PW-1:0]           SEEN_MAX = PW'(MAX_LEN - 1);

	logic [SAMPLE_WIDTH-1:0] raw_in;
	logic [SAMPLE_WIDTH-1:0] key_in;
	logic [SAMPLE_WIDTH-1:0] older_q;
	logic [SAMPLE_WIDTH-1:0] middle_q;
	logic [PW-1:0]           seen_q;
	logic                    peak;
	logic                    valley;

	// order-preserving unsigned key of the sample
	generate
		if (SAMPLE_WIDTH > 32) begin : g_wide
			assign raw_in = SAMPLE_WIDTH'(sample_value);
		end else begin : g_narrow
			assign raw_in = sample_value[SAMPLE_WIDTH-1:0];
		end
	endgenerate

	assign key_in = raw_in ^ SIGN_BIT;

	assign peak     = (middle_q > older_q) && (middle_q > key_in);
	assign valley   = (middle_q < older_q) && (middle_q < key_in);
	assign ctl.crit = (seen_q >= PW'(2)) && (peak || valley);
	assign ctl.last = is_last;
	assign pos      = seen_q - PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (take) begin
			if (is_last) begin
				seen_q <= '0;
			end else if (seen_q != SEEN_MAX) begin
				seen_q <= seen_q + PW'(1);
			end
		end
	end

	// history needs no reset: it is ignored until two samples arrived
	always_ff @(posedge clk) begin
		if (take) begin
			older_q  <= middle_q;
			middle_q <= key_in;
		end
	end

endmodule

/* rtl/cpdt_queue.sv */
// ----------------------------------------------------------------------------
// cpdt_queue
// two-entry queue between the classifying front and the tracking back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpdt_queue #(
	parameter int unsigned W = 18
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         full,
	output logic         empty
);
	import cpdt_pkg::*;

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

/* rtl/cpdt_back.sv */
// ----------------------------------------------------------------------------
// cpdt_back
// tracks critical positions and smallest gap, builds the sequence result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpdt_back #(
	parameter int unsigned PW = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ev_valid,
	input  cpdt_pkg::cpdt_ctl_t        ctl,
	input  logic [PW-1:0]              pos,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [cpdt_pkg::RES_W-1:0] min_gap,
	output logic [cpdt_pkg::RES_W-1:0] span
);
	import cpdt_pkg::*;

	localparam int unsigned GW = (PW > RES_W) ? PW : RES_W;

	logic [PW-1:0]    first_q;
	logic [PW-1:0]    last_q;
	logic [1:0]       count_q;
	logic [RES_W-1:0] gap_q;
	logic             out_valid_q;
	logic             found_q;
	logic [RES_W-1:0] min_gap_q;
	logic [RES_W-1:0] span_q;

	logic             slot_free;
	logic [PW-1:0]    gap;
	logic [GW-1:0]    gap_ext;
	logic [PW-1:0]    nxt_first;
	logic [PW-1:0]    nxt_last;
	logic [1:0]       nxt_count;
	logic [RES_W-1:0] nxt_gap;
	logic [GW-1:0]    span_ext;
	logic             nxt_found;

	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = ev_valid && (!ctl.last || slot_free);

	assign gap     = pos - last_q;
	assign gap_ext = GW'(gap);

	always_comb begin
		nxt_first = first_q;
		nxt_last  = last_q;
		nxt_count = count_q;
		nxt_gap   = gap_q;
		if (ctl.crit) begin
			if (count_q == 2'd0) begin
				nxt_first = pos;
			end else if (gap_ext < GW'(gap_q)) begin
				nxt_gap = gap_ext[RES_W-1:0];
			end
			nxt_last = pos;
			if (count_q != 2'd2) begin
				nxt_count = count_q + 2'd1;
			end
		end
	end

	assign span_ext  = GW'(nxt_last - nxt_first);
	assign nxt_found = (nxt_count == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= '0;
			last_q      <= '0;
			count_q     <= 2'd0;
			gap_q       <= GAP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (ctl.last) begin
					first_q <= '0;
					last_q  <= '0;
					count_q <= 2'd0;
					gap_q   <= GAP_NONE;
				end else begin
					first_q <= nxt_first;
					last_q  <= nxt_last;
					count_q <= nxt_count;
					gap_q   <= nxt_gap;
				end
			end
			if (pop && ctl.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && ctl.last) begin
			found_q   <= nxt_found;
			min_gap_q <= nxt_found ? nxt_gap : '0;
			span_q    <= nxt_found ? span_ext[RES_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign min_gap   = min_gap_q;
	assign span      = span_q;

endmodule

/* rtl/critical_point_distance_tracker_top.sv */
// ----------------------------------------------------------------------------
// critical_point_distance_tracker_top
// local peak / valley detector reporting gaps between critical points
// ----------------------------------------------------------------------------
// usage
//   input channel  : in_valid / in_stall, one sample_value per transfer,
//                    is_last marks the final sample of a sequence
//   output channel : out_valid / out_stall, one result transfer per sequence
//                    carrying found, min_gap and span
//   a middle sample strictly above or below both neighbours is critical;
//   found is 0 with fewer than two critical points, min_gap and span then 0
//   the result of a last sample is registered in the queue and then in the
//   back result register; throughput is one sample per cycle while in_stall
//   is low; the front compare and back gap subtract / min are combinational
//   the sample position counter saturates at MAX_LEN-1
//   reset clears the position counter, tracking state, queue and out_valid
//   a stalled result holds; samples keep flowing until the next last sample
//   waits behind it and one more fills the queue, then in_stall rises
//   after each last sample the block starts a fresh sequence by itself
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module critical_point_distance_tracker_top #(
	parameter int unsigned MAX_LEN      = 65536,
	parameter int unsigned SAMPLE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// sample input
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [31:0]                sample_value,
	input  logic                       is_last,
	// result output
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [cpdt_pkg::RES_W-1:0] min_gap,
	output logic [cpdt_pkg::RES_W-1:0] span
);
	import cpdt_pkg::*;

	// position counter width, holds MAX_LEN-1
	localparam int unsigned PW = $clog2(MAX_LEN);
	// queue entry: classification plus position
	localparam int unsigned QW = $bits(cpdt_ctl_t) + PW;

	logic          take;
	cpdt_ctl_t     front_ctl;
	logic [PW-1:0] front_pos;
	logic [QW-1:0] q_din;
	logic [QW-1:0] q_dout;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	cpdt_ctl_t     back_ctl;
	logic [PW-1:0] back_pos;

	// front only stalls when the queue has no room
	assign in_stall = q_full;
	assign take     = in_valid && !in_stall;

	cpdt_front #(
		.MAX_LEN      (MAX_LEN),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.PW           (PW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.sample_value (sample_value),
		.is_last      (is_last),
		.ctl          (front_ctl),
		.pos          (front_pos)
	);

	assign q_din = {front_ctl, front_pos};

	cpdt_queue #(
		.W      (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {back_ctl, back_pos} = q_dout;

	// back tracks positions and holds the result register
	cpdt_back #(
		.PW        (PW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (!q_empty),
		.ctl       (back_ctl),
		.pos       (back_pos),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.min_gap   (min_gap),
		.span      (span)
	);

endmodule

/* rtl/cpdt_checker.sv */
// ----------------------------------------------------------------------------
// cpdt_checker
// port-level checks of the critical point distance tracker, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "critical_point_distance_tracker_top_defines.svh"

module cpdt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       found,
	input logic [cpdt_pkg::RES_W-1:0] min_gap,
	input logic [cpdt_pkg::RES_W-1:0] span
);
	import cpdt_pkg::*;

	// a stalled result keeps its payload
	`CPDT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(found) && $stable(min_gap) && $stable(span), "stalled result changed")

	// no critical pair means zero gap and span
	`CPDT_ASSERT(a_not_found_zero, out_valid && !found |-> min_gap == '0 && span == '0, "result without pair has nonzero fields")

	// once reset has been seen at an edge, nothing is offered at the next one
	`CPDT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "result offered during reset")

endmodule

bind critical_point_distance_tracker_top cpdt_checker u_cpdt_checker (.*);
